// ----- sv/stream_vbyte_delta_decoder_defines.svh -----
// assertion macros used by the decoder top level
`ifndef STREAM_VBYTE_DELTA_DECODER_DEFINES_SVH
`define STREAM_VBYTE_DELTA_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define SVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stream_vbyte_delta_decoder: check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define SVD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stream_vbyte_delta_decoder: check failed");

`endif

// ----- sv/svd_pkg.sv -----
// shared types and constants of the stream vbyte delta decoder
package svd_pkg;

    localparam int BYTES_W = 19;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_BOUND  = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // one queue entry: a first result, optionally followed by four high-nibble bounds
    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        value;
        logic               pad;
        logic               frame_end;
        logic               err;
        logic [BYTES_W-1:0] bytes;
        logic               has_high;
        logic [15:0]        high_nib;
        logic [3:0]         high_pad;
        logic               high_end;
    } svd_entry_t;

endpackage

// ----- sv/svd_in_if.sv -----
// byte input channel
interface svd_in_if import svd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ----- sv/svd_out_if.sv -----
// decoded result channel
interface svd_out_if import svd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         item_kind;
    logic [31:0]        item_value;
    logic               is_padding;
    logic               frame_end;
    logic               count_error;
    logic [BYTES_W-1:0] bytes_used;

    modport source (output valid, output item_kind, output item_value, output is_padding,
                    output frame_end, output count_error, output bytes_used, input ready);
    modport sink (input valid, input item_kind, input item_value, input is_padding,
                  input frame_end, input count_error, input bytes_used, output ready);
endinterface

// ----- sv/svd_fifo.sv -----
// small queue between the parser and the result sequencer
module svd_fifo import svd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  svd_entry_t push_data,
    input  logic       pop,
    output svd_entry_t head,
    output logic       full,
    output logic       empty
);

    svd_entry_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/svd_front.sv -----
// frame parser: header, descriptors, value bytes, prefix sum and bound bytes
module svd_front import svd_pkg::*;
#(
    parameter int MAX_VALUES = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    svd_in_if.sink     byte_stream,
    input  logic       bounds_present,
    input  logic       q_full,
    output logic       push,
    output svd_entry_t push_data
);

    localparam int CW = $clog2(MAX_VALUES + 1);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DESC   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [1:0] PH_BOUNDS = 2'd3;

    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         hpos_reg, hpos_next;
    logic [23:0]        hdr_reg, hdr_next;
    logic [CW-1:0]      tc_reg, tc_next;
    logic [CW-1:0]      pc_reg, pc_next;
    logic [CW-1:0]      done_reg, done_next;
    logic [7:0]         desc_reg, desc_next;
    logic [1:0]         lane_reg, lane_next;
    logic [1:0]         biv_reg, biv_next;
    logic [23:0]        acc_reg, acc_next;
    logic [31:0]        sum_reg, sum_next;
    logic [11:0]        hi_reg, hi_next;
    logic [BYTES_W-1:0] total_reg, total_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] cnt;
    logic [32:0] padded;
    logic        hdr_err;
    logic [1:0]  len_m1;
    logic [31:0] full_val;
    logic [31:0] sum_new;
    logic [CW-1:0] done_inc;
    logic        last;
    logic [CW:0] done_p5;
    logic        bnd_end;
    logic [3:0]  hpad;

    assign b                 = byte_stream.data_byte;
    assign byte_stream.ready = !q_full;
    assign accept            = byte_stream.valid && !q_full;

    assign cnt      = {b, hdr_reg};
    assign padded   = ({1'b0, cnt} + 33'd7) & ~33'd7;
    assign hdr_err  = (padded > 33'(MAX_VALUES));
    assign len_m1   = desc_reg[{lane_reg, 1'b0} +: 2];
    assign full_val = {8'd0, acc_reg} | ({24'd0, b} << {biv_reg, 3'b000});
    assign sum_new  = sum_reg + full_val;
    assign done_inc = done_reg + 1'b1;
    assign last     = (done_inc >= pc_reg);
    assign done_p5  = {1'b0, done_reg} + (CW + 1)'(5);
    assign bnd_end  = (done_p5 >= {1'b0, pc_reg});

    // high nibble indices follow the fourth low nibble of the word
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            hpad[j] = (({1'b0, done_reg} + (CW + 1)'(j + 1)) >= {1'b0, tc_reg});
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        hdr_next   = hdr_reg;
        tc_next    = tc_reg;
        pc_next    = pc_reg;
        done_next  = done_reg;
        desc_next  = desc_reg;
        lane_next  = lane_reg;
        biv_next   = biv_reg;
        acc_next   = acc_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        total_next = total_reg;
        push       = 1'b0;
        push_data  = '0;

        if (accept)
        begin
            total_next      = total_reg + 1'b1;
            push_data.bytes = total_reg + 1'b1;
            case (phase_reg)
                PH_HEADER:
                begin
                    case (hpos_reg)
                        2'd0: hdr_next[7:0]   = b;
                        2'd1: hdr_next[15:8]  = b;
                        2'd2: hdr_next[23:16] = b;
                        default:
                        begin
                            push                = 1'b1;
                            push_data.kind      = KIND_HEADER;
                            push_data.value     = hdr_err ? cnt : cnt;
                            push_data.err       = hdr_err;
                            push_data.frame_end = hdr_err || (cnt == '0);
                            hdr_next            = '0;
                            if (hdr_err || (cnt == '0))
                            begin
                                total_next = '0;
                            end
                            else
                            begin
                                tc_next    = cnt[CW-1:0];
                                pc_next    = padded[CW-1:0];
                                done_next  = '0;
                                sum_next   = '0;
                                phase_next = PH_DESC;
                            end
                        end
                    endcase
                    hpos_next = hpos_reg + 1'b1;
                end
                PH_DESC:
                begin
                    desc_next  = b;
                    lane_next  = '0;
                    biv_next   = '0;
                    acc_next   = '0;
                    phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (biv_reg == len_m1)
                    begin
                        push                = 1'b1;
                        push_data.kind      = KIND_VALUE;
                        push_data.value     = sum_new;
                        push_data.pad       = (done_reg >= tc_reg);
                        push_data.frame_end = last && !bounds_present;
                        sum_next            = sum_new;
                        done_next           = done_inc;
                        acc_next            = '0;
                        biv_next            = '0;
                        if (last)
                        begin
                            if (bounds_present)
                            begin
                                phase_next = PH_BOUNDS;
                                done_next  = '0;
                                lane_next  = '0;
                                hi_next    = '0;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                                total_next = '0;
                            end
                        end
                        else if (lane_reg == 2'd3)
                        begin
                            phase_next = PH_DESC;
                        end
                        else
                        begin
                            lane_next = lane_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next = full_val[23:0];
                        biv_next = biv_reg + 1'b1;
                    end
                end
                default:
                begin
                    push            = 1'b1;
                    push_data.kind  = KIND_BOUND;
                    push_data.value = {28'd0, b[3:0]};
                    push_data.pad   = (done_reg >= tc_reg);
                    case (lane_reg)
                        2'd0: hi_next[3:0]  = b[7:4];
                        2'd1: hi_next[7:4]  = b[7:4];
                        2'd2: hi_next[11:8] = b[7:4];
                        default:
                        begin
                            push_data.has_high = 1'b1;
                            push_data.high_nib = {b[7:4], hi_reg};
                            push_data.high_pad = hpad;
                            push_data.high_end = bnd_end;
                        end
                    endcase
                    if (lane_reg == 2'd3)
                    begin
                        lane_next = '0;
                        hi_next   = '0;
                        done_next = done_p5[CW-1:0];
                        if (bnd_end)
                        begin
                            phase_next = PH_HEADER;
                            total_next = '0;
                        end
                    end
                    else
                    begin
                        lane_next = lane_reg + 1'b1;
                        done_next = done_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hpos_reg  <= '0;
            hdr_reg   <= '0;
            tc_reg    <= '0;
            pc_reg    <= '0;
            done_reg  <= '0;
            desc_reg  <= '0;
            lane_reg  <= '0;
            biv_reg   <= '0;
            acc_reg   <= '0;
            sum_reg   <= '0;
            hi_reg    <= '0;
            total_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            hdr_reg   <= hdr_next;
            tc_reg    <= tc_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
            desc_reg  <= desc_next;
            lane_reg  <= lane_next;
            biv_reg   <= biv_next;
            acc_reg   <= acc_next;
            sum_reg   <= sum_next;
            hi_reg    <= hi_next;
            total_reg <= total_next;
        end
    end

endmodule

// ----- sv/svd_back.sv -----
// result sequencer: expands queue entries into results behind an output register
module svd_back import svd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  svd_entry_t q_head,
    output logic       q_pop,
    svd_out_if.source  result_stream
);

    logic               ov_reg, ov_next;
    logic [1:0]         kind_reg, kind_next;
    logic [31:0]        val_reg, val_next;
    logic               pad_reg, pad_next;
    logic               end_reg, end_next;
    logic               err_reg, err_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic               hact_reg, hact_next;
    logic [1:0]         hidx_reg, hidx_next;
    logic [15:0]        hnib_reg, hnib_next;
    logic [3:0]         hpad_reg, hpad_next;
    logic               hend_reg, hend_next;
    logic [BYTES_W-1:0] hbytes_reg, hbytes_next;

    logic load;
    logic hlast;

    assign load  = !ov_reg || result_stream.ready;
    assign hlast = (hidx_reg == 2'd3) && hend_reg;

    always_comb
    begin
        ov_next     = ov_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        pad_next    = pad_reg;
        end_next    = end_reg;
        err_next    = err_reg;
        bytes_next  = bytes_reg;
        hact_next   = hact_reg;
        hidx_next   = hidx_reg;
        hnib_next   = hnib_reg;
        hpad_next   = hpad_reg;
        hend_next   = hend_reg;
        hbytes_next = hbytes_reg;
        q_pop       = 1'b0;

        if (load)
        begin
            if (hact_reg)
            begin
                // high nibbles of the bound word, one per transaction
                ov_next    = 1'b1;
                kind_next  = KIND_BOUND;
                val_next   = {28'd0, hnib_reg[{hidx_reg, 2'b00} +: 4]};
                pad_next   = hpad_reg[hidx_reg];
                end_next   = hlast;
                err_next   = 1'b0;
                bytes_next = hlast ? hbytes_reg : '0;
                hidx_next  = hidx_reg + 1'b1;
                if (hidx_reg == 2'd3)
                begin
                    hact_next = 1'b0;
                end
            end
            else if (!q_empty)
            begin
                q_pop      = 1'b1;
                ov_next    = 1'b1;
                kind_next  = q_head.kind;
                val_next   = q_head.value;
                pad_next   = q_head.pad;
                end_next   = q_head.frame_end;
                err_next   = q_head.err;
                bytes_next = q_head.frame_end ? q_head.bytes : '0;
                if (q_head.has_high)
                begin
                    hact_next   = 1'b1;
                    hidx_next   = '0;
                    hnib_next   = q_head.high_nib;
                    hpad_next   = q_head.high_pad;
                    hend_next   = q_head.high_end;
                    hbytes_next = q_head.bytes;
                end
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            hact_reg <= 1'b0;
            hidx_reg <= '0;
        end
        else
        begin
            ov_reg   <= ov_next;
            hact_reg <= hact_next;
            hidx_reg <= hidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        pad_reg    <= pad_next;
        end_reg    <= end_next;
        err_reg    <= err_next;
        bytes_reg  <= bytes_next;
        hnib_reg   <= hnib_next;
        hpad_reg   <= hpad_next;
        hend_reg   <= hend_next;
        hbytes_reg <= hbytes_next;
    end

    assign result_stream.valid       = ov_reg;
    assign result_stream.item_kind   = kind_reg;
    assign result_stream.item_value  = val_reg;
    assign result_stream.is_padding  = pad_reg;
    assign result_stream.frame_end   = end_reg;
    assign result_stream.count_error = err_reg;
    assign result_stream.bytes_used  = bytes_reg;

endmodule

// ----- sv/stream_vbyte_delta_decoder.sv -----
// stream vbyte delta decoder top level
// path: a byte that completes a result is written to the queue, then loaded into the output
//   register that drives result_stream
// throughput: one byte per cycle while the queue is not full; the last byte of each bound word
//   gives five results, drained at one per cycle while result_stream is ready
// reset: rst_n asynchronous active low; parser awaits a header, queue empty, bounds_present = 1
`include "stream_vbyte_delta_decoder_defines.svh"
module stream_vbyte_delta_decoder import svd_pkg::*;
#(
    parameter int MAX_VALUES = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    svd_in_if.sink    byte_stream,
    svd_out_if.source result_stream,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic       bounds_present_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    svd_entry_t q_in;
    svd_entry_t q_head;
    logic       res_err;
    logic       res_err_hdr;
    logic       res_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            bounds_present_reg <= cfg_wdata;
        end
    end

    svd_front #(.MAX_VALUES(MAX_VALUES)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_stream    (byte_stream),
        .bounds_present (bounds_present_reg),
        .q_full         (q_full),
        .push           (q_push),
        .push_data      (q_in)
    );

    svd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    svd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .result_stream (result_stream)
    );

    assign res_err     = result_stream.valid && result_stream.count_error;
    assign res_err_hdr = result_stream.frame_end && (result_stream.item_kind == KIND_HEADER);
    assign res_mid     = result_stream.valid && !result_stream.frame_end;

    `SVD_ASSERT_IMP(a_no_overflow, q_push, !q_full)
    `SVD_ASSERT_IMP(a_no_underflow, q_pop, !q_empty)
    `SVD_ASSERT_IMP(a_err_ends_frame, res_err, res_err_hdr)
    `SVD_ASSERT_IMP(a_bytes_only_at_end, res_mid, result_stream.bytes_used == '0)

endmodule

// ----- verif/tb_stream_vbyte_delta_decoder.sv -----
// self-checking testbench for the stream vbyte delta decoder
`timescale 1ns / 1ps

module tb_stream_vbyte_delta_decoder import svd_pkg::*;;

    localparam int MAX_COUNT    = 65536;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_BYTES  = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int DIR_ROWS     = 29;

    typedef enum logic [1:0] {ST_HEADER, ST_DESC, ST_VALUE, ST_BOUNDS} parse_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        value;
        logic               pad;
        logic               last;
        logic               err;
        logic [BYTES_W-1:0] used;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_want;
        result_t    want;
    } byte_item_t;

    localparam result_t NO_RESULT    = '0;
    localparam result_t EXP_ZERO_HDR = '{KIND_HEADER, 32'd0, 1'b0, 1'b1, 1'b0, 19'd4};
    localparam result_t EXP_OVER_HDR = '{KIND_HEADER, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 19'd4};
    localparam result_t EXP_ONE_HDR  = '{KIND_HEADER, 32'd1, 1'b0, 1'b0, 1'b0, 19'd0};

    // zero count, oversized count, then a count-1 frame with long and short lanes and bounds
    byte_item_t directed_rows [DIR_ROWS] = '{
        {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b1, EXP_ZERO_HDR},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b1, EXP_OVER_HDR},
        {8'h01, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b1, EXP_ONE_HDR},
        {8'h03, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'h02, 1'b0, NO_RESULT}, {8'h80, 1'b0, NO_RESULT},
        {8'h7F, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h01, 1'b0, NO_RESULT}, {8'hFE, 1'b0, NO_RESULT},
        {8'h10, 1'b0, NO_RESULT}, {8'hEF, 1'b0, NO_RESULT},
        {8'hA5, 1'b0, NO_RESULT}, {8'h0F, 1'b0, NO_RESULT},
        {8'hF0, 1'b0, NO_RESULT}, {8'h5A, 1'b0, NO_RESULT}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    svd_in_if  byte_if ();
    svd_out_if result_if ();

    stream_vbyte_delta_decoder #(
        .MAX_VALUES (MAX_COUNT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_if),
        .result_stream (result_if),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    byte_item_t  tx_q[$];
    result_t     expected_q[$];
    logic [7:0]  frame_buf[$];
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned stall_cycles;
    int unsigned fail_count;

    // decoder shadow state
    bit                 bounds_on;
    parse_t             cur_phase;
    int unsigned        hdr_pos;
    logic [31:0]        hdr_count;
    int unsigned        padded_count;
    int unsigned        items_seen;
    logic [7:0]         desc_byte;
    int unsigned        lane;
    int unsigned        byte_idx;
    logic [31:0]        accum;
    logic [31:0]        run_sum;
    logic [15:0]        hi_nib;
    logic [BYTES_W-1:0] byte_cnt;

    function automatic void clear_frame();
        cur_phase    = ST_HEADER;
        hdr_pos      = 0;
        hdr_count    = '0;
        padded_count = 0;
        items_seen   = 0;
        desc_byte    = '0;
        lane         = 0;
        byte_idx     = 0;
        accum        = '0;
        run_sum      = '0;
        hi_nib       = '0;
        byte_cnt     = '0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [31:0] value, bit pad,
                                        bit last, bit err);
        result_t r;
        r.kind  = kind;
        r.value = value;
        r.pad   = pad;
        r.last  = last;
        r.err   = err;
        r.used  = last ? byte_cnt : '0;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int unsigned len;
        int unsigned k;
        longint unsigned padded;
        bit pad;
        bit fin;
        byte_cnt = byte_cnt + 1'b1;
        case (cur_phase)
            ST_DESC:
            begin
                desc_byte = b;
                lane      = 0;
                byte_idx  = 0;
                accum     = '0;
                cur_phase = ST_VALUE;
            end
            ST_VALUE:
            begin
                len = ((desc_byte >> (2 * lane)) & 8'h03) + 1;
                accum = accum | (32'(b) << (8 * byte_idx));
                byte_idx++;
                if (byte_idx >= len)
                begin
                    pad = (items_seen >= hdr_count);
                    run_sum = run_sum + accum;
                    items_seen++;
                    fin = (items_seen >= padded_count);
                    push_result(KIND_VALUE, run_sum, pad, fin && !bounds_on, 1'b0);
                    accum    = '0;
                    byte_idx = 0;
                    if (fin)
                    begin
                        if (bounds_on)
                        begin
                            cur_phase  = ST_BOUNDS;
                            items_seen = 0;
                            lane       = 0;
                            hi_nib     = '0;
                        end
                        else
                        begin
                            clear_frame();
                        end
                    end
                    else if (lane >= 3)
                    begin
                        cur_phase = ST_DESC;
                    end
                    else
                    begin
                        lane++;
                    end
                end
            end
            ST_BOUNDS:
            begin
                k   = lane;
                fin = 1'b0;
                push_result(KIND_BOUND, 32'(b[3:0]), items_seen >= hdr_count, 1'b0, 1'b0);
                items_seen++;
                hi_nib = hi_nib | (16'(b[7:4]) << (4 * k));
                if (k == 3)
                begin
                    // the fourth byte of a word releases the four high-nibble bounds
                    for (int j = 0; j < 4; j++)
                    begin
                        pad = (items_seen >= hdr_count);
                        items_seen++;
                        fin = (j == 3) && (items_seen >= padded_count);
                        push_result(KIND_BOUND, 32'((hi_nib >> (4 * j)) & 16'h000F), pad,
                                    fin, 1'b0);
                    end
                    lane   = 0;
                    hi_nib = '0;
                    if (fin)
                        clear_frame();
                end
                else
                begin
                    lane = k + 1;
                end
            end
            default:
            begin
                hdr_count = hdr_count | (32'(b) << (8 * hdr_pos));
                if (hdr_pos >= 3)
                begin
                    padded  = (longint'(hdr_count) + 7) / 8 * 8;
                    hdr_pos = 0;
                    if (padded > MAX_COUNT)
                    begin
                        push_result(KIND_HEADER, hdr_count, 1'b0, 1'b1, 1'b1);
                        clear_frame();
                    end
                    else if (hdr_count == 0)
                    begin
                        push_result(KIND_HEADER, 32'd0, 1'b0, 1'b1, 1'b0);
                        clear_frame();
                    end
                    else
                    begin
                        push_result(KIND_HEADER, hdr_count, 1'b0, 1'b0, 1'b0);
                        padded_count = int'(padded);
                        items_seen   = 0;
                        run_sum      = '0;
                        cur_phase    = ST_DESC;
                    end
                end
                else
                begin
                    hdr_pos++;
                end
            end
        endcase
    endfunction

    // handshakes, prediction, checking, watchdog and driving share one process
    always @(posedge clk)
    begin : stream_ctrl
        byte_item_t  sent;
        result_t     got;
        result_t     want;
        int unsigned n0;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (byte_if.valid && byte_if.ready)
            begin
                moved = 1'b1;
                sent  = tx_q.pop_front();
                n0    = expected_q.size();
                decode_byte(sent.data);
                if (sent.has_want)
                begin
                    while (expected_q.size() > n0)
                        void'(expected_q.pop_back());
                    expected_q.insert(expected_q.size(), sent.want);
                end
            end
            if (result_if.valid && result_if.ready)
            begin
                moved = 1'b1;
                got.kind  = result_if.item_kind;
                got.value = result_if.item_value;
                got.pad   = result_if.is_padding;
                got.last  = result_if.frame_end;
                got.err   = result_if.count_error;
                got.used  = result_if.bytes_used;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: kind=%0d value=%h end=%b",
                                 got.kind, got.value, got.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("exp kind=%0d value=%h pad=%b end=%b err=%b used=%0d",
                                     want.kind, want.value, want.pad, want.last, want.err,
                                     want.used);
                            $display("act kind=%0d value=%h pad=%b end=%b err=%b used=%0d",
                                     got.kind, got.value, got.pad, got.last, got.err, got.used);
                        end
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_stream_vbyte_delta_decoder NOT OK");
                $finish;
            end
            else
            begin
                // a held byte stays on the bus until it is taken
                if (!(byte_if.valid && !byte_if.ready))
                begin
                    if (tx_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                    begin
                        byte_if.valid     <= 1'b1;
                        byte_if.data_byte <= tx_q[0].data;
                    end
                    else
                    begin
                        byte_if.valid <= 1'b0;
                    end
                end
                result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
        else
        begin
            byte_if.valid     <= 1'b0;
            byte_if.data_byte <= '0;
            result_if.ready   <= 1'b0;
        end
    end

    task automatic wait_idle();
        while (tx_q.size() != 0 || expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_bounds(input bit v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bounds_on = v;
        @(negedge clk);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        byte_item_t it;
        it.data     = b;
        it.has_want = 1'b0;
        it.want     = NO_RESULT;
        tx_q.insert(tx_q.size(), it);
    endtask

    task automatic queue_frame_buf();
        foreach (frame_buf[i])
            queue_byte(frame_buf[i]);
    endtask

    // header, groups with random descriptors and lane bytes, then optional bounds
    task automatic build_frame(input logic [31:0] count, input bit with_bounds);
        longint unsigned padded;
        logic [7:0] d;
        frame_buf.delete();
        for (int i = 0; i < 4; i++)
            frame_buf.insert(frame_buf.size(), count[8*i +: 8]);
        padded = (longint'(count) + 7) / 8 * 8;
        if (count != 0 && padded <= MAX_COUNT)
        begin
            for (int g = 0; g < int'(padded) / 4; g++)
            begin
                d = 8'($urandom_range(255));
                frame_buf.insert(frame_buf.size(), d);
                for (int ln = 0; ln < 4; ln++)
                    for (int k = 0; k <= int'((d >> (2 * ln)) & 8'h03); k++)
                        frame_buf.insert(frame_buf.size(), 8'($urandom_range(255)));
            end
            if (with_bounds)
                for (int i = 0; i < int'(padded) / 2; i++)
                    frame_buf.insert(frame_buf.size(), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin : main_seq
        int unsigned phase_bytes;
        int unsigned r;
        int unsigned held_padded;
        logic [31:0] count;
        logic [7:0]  held_byte;
        bit          held_pending;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        stall_cycles      = 0;
        fail_count        = 0;
        held_pending      = 1'b0;
        held_padded       = 0;
        held_byte         = '0;
        bounds_on         = 1'b1;
        clear_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_bounds(1'b1);
        foreach (directed_rows[i])
            tx_q.insert(tx_q.size(), directed_rows[i]);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p / 2)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            write_bounds(p % 2 == 1);
            // finish the frame left open across the register write
            if (held_pending)
            begin
                queue_byte(held_byte);
                if (bounds_on)
                    for (int i = 0; i < int'(held_padded) / 2; i++)
                        queue_byte(8'($urandom_range(255)));
                held_pending = 1'b0;
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                r = $urandom_range(99);
                if (r < 8)
                    count = '0;
                else if (r < 13)
                    count = $urandom_range(65600, MAX_COUNT + 1);
                else if (r < 18)
                    count = $urandom_range(32'hFFFF_FFFF, MAX_COUNT + 1);
                else
                    count = $urandom_range(10, 1);
                build_frame(count, bounds_on);
                phase_bytes += frame_buf.size();
                queue_frame_buf();
            end
            if (p < NUM_PHASES - 1)
            begin
                // stop just before the last value completes
                count = $urandom_range(8, 1);
                build_frame(count, 1'b0);
                held_byte    = frame_buf.pop_back();
                held_padded  = (count + 7) / 8 * 8;
                held_pending = 1'b1;
                queue_frame_buf();
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("tb_stream_vbyte_delta_decoder OK");
        else
            $display("tb_stream_vbyte_delta_decoder NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/svd_pkg.sv
sv/svd_in_if.sv
sv/svd_out_if.sv
sv/svd_fifo.sv
sv/svd_front.sv
sv/svd_back.sv
sv/stream_vbyte_delta_decoder.sv
verif/tb_stream_vbyte_delta_decoder.sv
